@@ rtl/core/rbbu_pkg.sv @@
// Shared types, constants and lookup tables of the radial brush blade update block.
`default_nettype none
package rbbu_pkg;

   localparam int RAD_W    = 40;   // squared distance, Q.16
   localparam int ROOT_W   = 20;   // distance, Q.8
   localparam int DIV_W    = 16;   // falloff fraction bits
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BRUSH_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HARDNESS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_AMOUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SIZE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_MODE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_VALUE   = 3'd7;

   // texture modes
   localparam logic [1:0] MODE_RANDOM = 2'd0;
   localparam logic [1:0] MODE_FIXED  = 2'd1;
   localparam logic [1:0] MODE_ERASE  = 2'd2;

   // divide by one million: multiply by floor(2^40/1e6), then one correction step
   localparam logic [20:0] RND_RECIP = 21'd1099511;
   localparam logic [19:0] RND_SCALE = 20'd1000000;

   typedef struct packed {
      logic [10:0] column_half;
      logic [7:0]  row;
      logic [15:0] size_in;
      logic [7:0]  tex_in;
   } req_type;

   typedef struct packed {
      logic [15:0] size_out;
      logic [7:0]  tex_out;
   } rsp_type;

   // what travels alongside the distance and falloff pipelines
   typedef struct packed {
      logic [15:0] size;
      logic [7:0]  tex;
      logic [7:0]  rtex;   // random-mode texture, already saturated
      logic        near;   // d <= inner radius
      logic        band;   // inner < d < outer
   } side_type;

   localparam logic [16:0] COS_TAB [0:16] = '{
      17'd65536, 17'd64906, 17'd63042, 17'd60014, 17'd55938, 17'd50973,
      17'd45308, 17'd39161, 17'd32768, 17'd26375, 17'd20228, 17'd14563,
      17'd9598,  17'd5522,  17'd2494,  17'd630,   17'd0
   };

   // random texture fractions in millionths, indexed {column mod 32, row mod 16}
   localparam logic [19:0] RND_TAB [0:511] = '{
      20'd405969,20'd392239,20'd878866,20'd459129,20'd848916,20'd919238,20'd912206,20'd962871,
      20'd30044,20'd90258,20'd864877,20'd66566,20'd795290,20'd721085,20'd308040,20'd254518,
      20'd763030,20'd920112,20'd191238,20'd805926,20'd444725,20'd767358,20'd620396,20'd672658,
      20'd911896,20'd807828,20'd293004,20'd281759,20'd924713,20'd487052,20'd925688,20'd365963,
      20'd310027,20'd97929,20'd591121,20'd552560,20'd502873,20'd223166,20'd458464,20'd219205,
      20'd284676,20'd644093,20'd794510,20'd886058,20'd894507,20'd358188,20'd784123,20'd706835,
      20'd274343,20'd160676,20'd754874,20'd515924,20'd641834,20'd328807,20'd729110,20'd625624,
      20'd19394,20'd339213,20'd215510,20'd116131,20'd881523,20'd353697,20'd145361,20'd896133,
      20'd271271,20'd719669,20'd377551,20'd607439,20'd89192,20'd830156,20'd528555,20'd2136,
      20'd872919,20'd254207,20'd571819,20'd667156,20'd840168,20'd850344,20'd618076,20'd214381,
      20'd104324,20'd432277,20'd350759,20'd762068,20'd38962,20'd1915,20'd137049,20'd992254,
      20'd371288,20'd740539,20'd947156,20'd454277,20'd984214,20'd549647,20'd599874,20'd373834,
      20'd851525,20'd831727,20'd514827,20'd539019,20'd134521,20'd145037,20'd19983,20'd136243,
      20'd563797,20'd890113,20'd5276,20'd854133,20'd406074,20'd299797,20'd887061,20'd615522,
      20'd720874,20'd400167,20'd967350,20'd606636,20'd806449,20'd427717,20'd544443,20'd647135,
      20'd305752,20'd262866,20'd449594,20'd902004,20'd778083,20'd320822,20'd635312,20'd901707,
      20'd554152,20'd311421,20'd179141,20'd430738,20'd378359,20'd700991,20'd865997,20'd253290,
      20'd496615,20'd500567,20'd743194,20'd681664,20'd138556,20'd583597,20'd610934,20'd537461,
      20'd198191,20'd364522,20'd982758,20'd826194,20'd639577,20'd803604,20'd413725,20'd439104,
      20'd106566,20'd648633,20'd70278,20'd929952,20'd911758,20'd27086,20'd912507,20'd514832,
      20'd631996,20'd478758,20'd16080,20'd672620,20'd249862,20'd11424,20'd349170,20'd387477,
      20'd441899,20'd393304,20'd716857,20'd530354,20'd618497,20'd719060,20'd549358,20'd997187,
      20'd645930,20'd672242,20'd99478,20'd251292,20'd528437,20'd402472,20'd178924,20'd372586,
      20'd381622,20'd615047,20'd811542,20'd8567,20'd296624,20'd550430,20'd842745,20'd381385,
      20'd863694,20'd990070,20'd496353,20'd896292,20'd769303,20'd264870,20'd815817,20'd52818,
      20'd686600,20'd916524,20'd313957,20'd632342,20'd858419,20'd964106,20'd706936,20'd12441,
      20'd367223,20'd309409,20'd50882,20'd689192,20'd540611,20'd715318,20'd873311,20'd608447,
      20'd391050,20'd393827,20'd992629,20'd915124,20'd502286,20'd565565,20'd316394,20'd990734,
      20'd183723,20'd252211,20'd4756,20'd584194,20'd750593,20'd313983,20'd976621,20'd20989,
      20'd876857,20'd159834,20'd736977,20'd953991,20'd365179,20'd841656,20'd782023,20'd460172,
      20'd247726,20'd762032,20'd227807,20'd940736,20'd927399,20'd583915,20'd595383,20'd711921,
      20'd215337,20'd896633,20'd8417,20'd797368,20'd124650,20'd845254,20'd698257,20'd754809,
      20'd841189,20'd764018,20'd872941,20'd721540,20'd257034,20'd9021,20'd576707,20'd261184,
      20'd335888,20'd565719,20'd570807,20'd852204,20'd723620,20'd547577,20'd219046,20'd386267,
      20'd126395,20'd522031,20'd35773,20'd100333,20'd695392,20'd115187,20'd74158,20'd332568,
      20'd71375,20'd75987,20'd770899,20'd493649,20'd4272,20'd72283,20'd239257,20'd521573,
      20'd62655,20'd629607,20'd987251,20'd506893,20'd305432,20'd213176,20'd901542,20'd56404,
      20'd65640,20'd205036,20'd247912,20'd24248,20'd376320,20'd33496,20'd238548,20'd756364,
      20'd639125,20'd298803,20'd394121,20'd970172,20'd728861,20'd836136,20'd566601,20'd298257,
      20'd39583,20'd865921,20'd66399,20'd635790,20'd629730,20'd549633,20'd303444,20'd417837,
      20'd142525,20'd792256,20'd82356,20'd169104,20'd850038,20'd78190,20'd797706,20'd503161,
      20'd415890,20'd193946,20'd951787,20'd575081,20'd657962,20'd28769,20'd927323,20'd61911,
      20'd27218,20'd554432,20'd663268,20'd219340,20'd5454,20'd257556,20'd3475,20'd833641,
      20'd432171,20'd406110,20'd41492,20'd21890,20'd11586,20'd45822,20'd520004,20'd481041,
      20'd925500,20'd404498,20'd66515,20'd797681,20'd517028,20'd344514,20'd413618,20'd679883,
      20'd916656,20'd66306,20'd420569,20'd261709,20'd357498,20'd738385,20'd267459,20'd578680,
      20'd901111,20'd80810,20'd433773,20'd814882,20'd679549,20'd380199,20'd413843,20'd221910,
      20'd561342,20'd55835,20'd250872,20'd526401,20'd774884,20'd921771,20'd760864,20'd213783,
      20'd443227,20'd287280,20'd455529,20'd864305,20'd248536,20'd931311,20'd914407,20'd653411,
      20'd151566,20'd128634,20'd573131,20'd436439,20'd873170,20'd55269,20'd929506,20'd858692,
      20'd5972,20'd349128,20'd115890,20'd997496,20'd547524,20'd35393,20'd492649,20'd99316,
      20'd156449,20'd724996,20'd520946,20'd864315,20'd552452,20'd953383,20'd460914,20'd466634,
      20'd908570,20'd614083,20'd175516,20'd925066,20'd435864,20'd478445,20'd859734,20'd11182,
      20'd631671,20'd19665,20'd456945,20'd109075,20'd244264,20'd699284,20'd116644,20'd89241,
      20'd242045,20'd780626,20'd496004,20'd391266,20'd21154,20'd692164,20'd740528,20'd967745,
      20'd483281,20'd969657,20'd270476,20'd372262,20'd793195,20'd743059,20'd102361,20'd486106,
      20'd408881,20'd135786,20'd904969,20'd102674,20'd235995,20'd16939,20'd76023,20'd750193,
      20'd7616,20'd903747,20'd158472,20'd587542,20'd406742,20'd799827,20'd105861,20'd388844,
      20'd674866,20'd466963,20'd537744,20'd53052,20'd688532,20'd323580,20'd563366,20'd253022,
      20'd790769,20'd104693,20'd356510,20'd582956,20'd121341,20'd500414,20'd440814,20'd400801,
      20'd69062,20'd15625,20'd325918,20'd330822,20'd813807,20'd839310,20'd706137,20'd305055,
      20'd136701,20'd792779,20'd548996,20'd75125,20'd425619,20'd335440,20'd627712,20'd398265,
      20'd159238,20'd52287,20'd445537,20'd792835,20'd271463,20'd273302,20'd232811,20'd599184,
      20'd890558,20'd339914,20'd796652,20'd581978,20'd834389,20'd404426,20'd723437,20'd119053
   };

endpackage
`default_nettype wire

@@ rtl/core/rbbu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rbbu_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         in_valid,
   input  wire logic [rbbu_pkg::RAD_W-1:0]   in_rad,
   input  wire rbbu_pkg::side_type           in_side,
   output logic                              out_valid,
   output logic [rbbu_pkg::ROOT_W-1:0]       out_root,
   output rbbu_pkg::side_type                out_side
);

   localparam int NS = rbbu_pkg::ROOT_W;

   logic                       valid_ff [0:NS-1];
   logic [rbbu_pkg::RAD_W-1:0] rem_ff   [0:NS-1];
   logic [NS-1:0]              root_ff  [0:NS-1];
   rbbu_pkg::side_type         side_ff  [0:NS-1];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int J = NS - 1 - s;
      logic                       src_valid;
      logic [rbbu_pkg::RAD_W-1:0] src_rem;
      logic [NS-1:0]              src_root;
      rbbu_pkg::side_type         src_side;
      logic [rbbu_pkg::RAD_W:0]   trial;
      logic                       take;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rad;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_root  = root_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
      assign trial = ((rbbu_pkg::RAD_W+1)'(src_root) << (J + 1))
                   | ((rbbu_pkg::RAD_W+1)'(1) << (2 * J));
      assign take  = {1'b0, src_rem} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= take ? (src_rem - trial[rbbu_pkg::RAD_W-1:0]) : src_rem;
            root_ff[s] <= src_root | (NS'(take) << J);
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule
`default_nettype wire

@@ rtl/core/rbbu_div.sv @@
// Pipelined restoring divider for the falloff fraction, one quotient bit per stage.
`default_nettype none
module rbbu_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [rbbu_pkg::DIV_W-1:0]  in_num,   // below den; dividend is num*2^DIV_W
   input  wire logic [rbbu_pkg::DIV_W-1:0]  den,
   input  wire rbbu_pkg::side_type          in_side,
   output logic                             out_valid,
   output logic [rbbu_pkg::DIV_W-1:0]       out_quo,
   output rbbu_pkg::side_type               out_side
);

   localparam int NS = rbbu_pkg::DIV_W;

   logic               valid_ff [0:NS-1];
   logic [NS-1:0]      rem_ff   [0:NS-1];
   logic [NS-1:0]      quo_ff   [0:NS-1];
   rbbu_pkg::side_type side_ff  [0:NS-1];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic               src_valid;
      logic [NS-1:0]      src_rem;
      logic [NS-1:0]      src_quo;
      rbbu_pkg::side_type src_side;
      logic [NS:0]        dbl;
      logic               take;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_quo   = quo_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      assign dbl  = {src_rem, 1'b0};
      assign take = dbl >= {1'b0, den};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= take ? NS'(dbl - {1'b0, den}) : dbl[NS-1:0];
            quo_ff[s]  <= {src_quo[NS-2:0], take};
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule
`default_nettype wire

@@ rtl/core/radial_brush_blade_update_top.sv @@
// Top level of the radial brush blade update pipeline.
// One grid element (blade) enters per transaction and one updated size/texture leaves per
// transaction, in order. The pipeline takes a new transaction every cycle while the output
// is not stalled. From acceptance to rsp_valid an element passes position, squaring and
// random-texture math (S1 to S5), square root (one root bit per stage), band
// classification (P1), falloff division (one quotient bit per stage), cosine lookup,
// interpolation and strength multiply, and the output register. All stages advance together
// whenever the output register is empty or being drained, so req_ready follows rsp_ready
// and a stalled output holds every element in flight. Registers are written through the
// csr_ port (always ready) and must only change while no transaction is in flight.
`default_nettype none
module radial_brush_blade_update_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire rbbu_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output rbbu_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rbbu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rbbu_pkg::CSR_DATA_W-1:0]    csr_data
);

   // ---------------- configuration registers ----------------
   logic [18:0] center_x_ff;
   logic [16:0] center_z_ff;
   logic [15:0] radius_ff;
   logic [8:0]  hardness_ff;
   logic [15:0] step_ff;
   logic [15:0] max_size_ff;
   logic [1:0]  mode_ff;
   logic [8:0]  tex_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_z_ff  <= '0;
         radius_ff    <= '0;
         hardness_ff  <= 9'd256;
         step_ff      <= '0;
         max_size_ff  <= 16'hFFFF;
         mode_ff      <= rbbu_pkg::MODE_FIXED;
         tex_value_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            rbbu_pkg::REG_CENTER_X:     center_x_ff  <= csr_data[18:0];
            rbbu_pkg::REG_CENTER_Z:     center_z_ff  <= csr_data[16:0];
            rbbu_pkg::REG_BRUSH_RADIUS: radius_ff    <= csr_data[15:0];
            rbbu_pkg::REG_HARDNESS:     hardness_ff  <= csr_data[8:0];
            rbbu_pkg::REG_STEP_AMOUNT:  step_ff      <= csr_data[15:0];
            rbbu_pkg::REG_MAX_SIZE:     max_size_ff  <= csr_data[15:0];
            rbbu_pkg::REG_TEX_MODE:     mode_ff      <= csr_data[1:0];
            rbbu_pkg::REG_TEX_VALUE:    tex_value_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Derived radii, re-registered every cycle; they settle long before a transaction
   // reaches the classification stage.
   logic [16:0] inner_ff;     // floor(hardness*radius/256)
   logic [15:0] band_den_ff;  // radius - inner when positive
   logic [24:0] inner_prod;

   assign inner_prod = hardness_ff * radius_ff;

   always_ff @(posedge clock) begin
      inner_ff    <= inner_prod[24:8];
      band_den_ff <= ({1'b0, radius_ff} > inner_ff) ? 16'(radius_ff - inner_ff[15:0]) : '0;
   end

   // ---------------- global advance ----------------
   logic rsp_valid_ff;
   logic adv;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- S1: offsets, random table read ----------------
   logic              v1_ff;
   rbbu_pkg::req_type it1_ff;
   logic signed [19:0] dx1_ff;
   logic signed [17:0] dz1_ff;
   logic [19:0]       rnd1_ff;
   logic [17:0]       px;
   logic [15:0]       pz;

   assign px = {req_data.column_half, 7'b0};
   assign pz = {req_data.row, req_data.column_half[0], 7'b0};

   // ---------------- S2: squares, random product ----------------
   logic              v2_ff;
   rbbu_pkg::req_type it2_ff;
   logic [38:0]       dxx2_ff;
   logic [38:0]       dzz2_ff;
   logic [28:0]       p2_ff;
   logic signed [39:0] dxx_full;
   logic signed [35:0] dzz_full;

   assign dxx_full = dx1_ff * dx1_ff;
   assign dzz_full = dz1_ff * dz1_ff;

   // ---------------- S3: sum, reciprocal estimate ----------------
   logic              v3_ff;
   rbbu_pkg::req_type it3_ff;
   logic [rbbu_pkg::RAD_W-1:0] rad3_ff;
   logic [28:0]       p3_ff;
   logic [9:0]        qe3_ff;
   logic [49:0]       recip_prod;

   assign recip_prod = p2_ff * rbbu_pkg::RND_RECIP;

   // ---------------- S4: back-multiply ----------------
   logic              v4_ff;
   rbbu_pkg::req_type it4_ff;
   logic [rbbu_pkg::RAD_W-1:0] rad4_ff;
   logic [28:0]       p4_ff;
   logic [9:0]        qe4_ff;
   logic [29:0]       qm4_ff;

   // ---------------- S5: correction, saturate ----------------
   logic              v5_ff;
   rbbu_pkg::side_type side5_ff;
   logic [rbbu_pkg::RAD_W-1:0] rad5_ff;
   logic [29:0]       rem4;
   logic [9:0]        q4;

   assign rem4 = {1'b0, p4_ff} - qm4_ff;
   assign q4   = qe4_ff + 10'(rem4 >= 30'(rbbu_pkg::RND_SCALE));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff  <= req_data;
         dx1_ff  <= $signed({2'b00, px}) - $signed({1'b0, center_x_ff});
         dz1_ff  <= $signed({2'b00, pz}) - $signed({1'b0, center_z_ff});
         rnd1_ff <= rbbu_pkg::RND_TAB[{req_data.column_half[4:0], req_data.row[3:0]}];

         it2_ff  <= it1_ff;
         dxx2_ff <= dxx_full[38:0];
         dzz2_ff <= {3'b000, dzz_full};
         p2_ff   <= rnd1_ff * tex_value_ff;

         it3_ff  <= it2_ff;
         rad3_ff <= {1'b0, dxx2_ff} + {1'b0, dzz2_ff};
         p3_ff   <= p2_ff;
         qe3_ff  <= recip_prod[49:40];

         it4_ff  <= it3_ff;
         rad4_ff <= rad3_ff;
         p4_ff   <= p3_ff;
         qe4_ff  <= qe3_ff;
         qm4_ff  <= qe3_ff * rbbu_pkg::RND_SCALE;

         rad5_ff       <= rad4_ff;
         side5_ff.size <= it4_ff.size_in;
         side5_ff.tex  <= it4_ff.tex_in;
         side5_ff.rtex <= (q4 > 10'd255) ? 8'hFF : q4[7:0];
         side5_ff.near <= 1'b0;
         side5_ff.band <= 1'b0;
      end
   end

   // ---------------- distance ----------------
   logic                        sq_valid;
   logic [rbbu_pkg::ROOT_W-1:0] sq_root;
   rbbu_pkg::side_type          sq_side;

   rbbu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_rad    (rad5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- P1: classify against inner/outer radius ----------------
   logic               vp1_ff;
   rbbu_pkg::side_type sidep1_ff;
   logic [15:0]        diffp1_ff;
   logic               near_c;
   logic               band_c;

   assign near_c = sq_root <= {3'b000, inner_ff};
   assign band_c = !near_c && (sq_root < {4'b0000, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vp1_ff <= 1'b0;
      end else if (adv) begin
         vp1_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidep1_ff.size <= sq_side.size;
         sidep1_ff.tex  <= sq_side.tex;
         sidep1_ff.rtex <= sq_side.rtex;
         sidep1_ff.near <= near_c;
         sidep1_ff.band <= band_c;
         diffp1_ff      <= sq_root[15:0] - inner_ff[15:0];
      end
   end

   // ---------------- falloff fraction ----------------
   logic                       dv_valid;
   logic [rbbu_pkg::DIV_W-1:0] dv_quo;
   rbbu_pkg::side_type         dv_side;

   rbbu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vp1_ff),
      .in_num    (diffp1_ff),
      .den       (band_den_ff),
      .in_side   (sidep1_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ---------------- P2: cosine table and interpolation product ----------------
   logic               vp2_ff;
   rbbu_pkg::side_type sidep2_ff;
   logic [16:0]        cosa_p2_ff;
   logic [12:0]        interp_p2_ff;
   logic [16:0]        cos_a;
   logic [16:0]        cos_b;
   logic [16:0]        cos_gap;
   logic [28:0]        interp_prod;

   assign cos_a       = rbbu_pkg::COS_TAB[5'(dv_quo[15:12])];
   assign cos_b       = rbbu_pkg::COS_TAB[5'(dv_quo[15:12]) + 5'd1];
   assign cos_gap     = cos_a - cos_b;
   assign interp_prod = cos_gap * dv_quo[11:0];

   // ---------------- P3: weight ----------------
   logic               vp3_ff;
   rbbu_pkg::side_type sidep3_ff;
   logic [16:0]        wp3_ff;

   // ---------------- P4: strength multiply ----------------
   logic               vp4_ff;
   rbbu_pkg::side_type sidep4_ff;
   logic               wnz4_ff;
   logic signed [33:0] prod4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp2_ff <= 1'b0;
         vp3_ff <= 1'b0;
         vp4_ff <= 1'b0;
      end else if (adv) begin
         vp2_ff <= dv_valid;
         vp3_ff <= vp2_ff;
         vp4_ff <= vp3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidep2_ff    <= dv_side;
         cosa_p2_ff   <= cos_a;
         interp_p2_ff <= interp_prod[24:12];

         sidep3_ff <= sidep2_ff;
         if (sidep2_ff.band) begin
            wp3_ff <= cosa_p2_ff - {4'b0000, interp_p2_ff};
         end else begin
            wp3_ff <= sidep2_ff.near ? 17'h10000 : 17'h00000;
         end

         sidep4_ff <= sidep3_ff;
         wnz4_ff   <= wp3_ff != '0;
         prod4_ff  <= $signed({1'b0, wp3_ff}) * $signed(step_ff);
      end
   end

   // ---------------- P5: mode select, clamp, output register ----------------
   rbbu_pkg::rsp_type   rsp_data_ff;
   logic signed [16:0]  delta;
   logic signed [17:0]  grown;
   logic signed [17:0]  size_ns;
   logic [7:0]          tex_ns;
   logic [7:0]          fixed_idx;
   logic [15:0]         size_clamped;

   // floor(prod / 65536) is an arithmetic shift
   assign delta     = prod4_ff[32:16];
   assign grown     = $signed({2'b00, sidep4_ff.size}) + 18'(delta);
   assign fixed_idx = tex_value_ff[7:0];

   always_comb begin
      size_ns = '0;
      tex_ns  = '0;
      case (mode_ff)
         rbbu_pkg::MODE_RANDOM: begin
            size_ns = grown;
            tex_ns  = sidep4_ff.rtex;
         end
         rbbu_pkg::MODE_FIXED: begin
            if (fixed_idx == sidep4_ff.tex) begin
               size_ns = grown;
               tex_ns  = sidep4_ff.tex;
            end else if (wnz4_ff) begin
               // replace the blade with the new texture
               size_ns = 18'(delta);
               tex_ns  = fixed_idx;
            end else begin
               size_ns = $signed({2'b00, sidep4_ff.size});
               tex_ns  = sidep4_ff.tex;
            end
         end
         default: begin
            // erase, and the unused fourth code
            size_ns = '0;
            tex_ns  = '0;
         end
      endcase
   end

   always_comb begin
      if (size_ns < 0) begin
         size_clamped = '0;
      end else if (size_ns > $signed({2'b00, max_size_ff})) begin
         size_clamped = max_size_ff;
      end else begin
         size_clamped = size_ns[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vp4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.size_out <= size_clamped;
         rsp_data_ff.tex_out  <= tex_ns;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/rbbu_check.sv @@
// Port-level checker for the radial brush blade update block, with its bind.
`default_nettype none
module rbbu_check (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire rbbu_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an empty output register never backpressures the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a stalled output blocks the input, as the whole pipeline is frozen
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind radial_brush_blade_update_top rbbu_check u_rbbu_check (.*);
`default_nettype wire

@@ tb/radial_brush_blade_update_top_tb.sv @@
// Self-checking testbench of the radial brush blade update block.
`default_nettype none
module radial_brush_blade_update_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 46;
   localparam int CYCLE_CAP = 400000;
   localparam int REQ_W     = $bits(rbbu_pkg::req_type);

   // brush settings as the predictor sees them
   typedef struct {
      logic [18:0] center_x;
      logic [16:0] center_z;
      logic [15:0] brush_radius;
      logic [8:0]  hardness;
      logic [15:0] step_amount;
      logic [15:0] max_size;
      logic [1:0]  tex_mode;
      logic [8:0]  tex_value;
   } brush_cfg_type;

   // predicts each element update and holds the pending ones in order
   class blade_scoreboard;
      rbbu_pkg::rsp_type pending[$];
      int unsigned mismatches;
      int unsigned checked;

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > v) bit_v >>= 2;
         while (bit_v != 0) begin
            if (v >= res + bit_v) begin
               v -= res + bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res >>= 1;
            end
            bit_v >>= 2;
         end
         return res;
      endfunction

      function rbbu_pkg::rsp_type predict_blade(rbbu_pkg::req_type r, brush_cfg_type c);
         longint px, pz, dx, dz, amt, prod, delta, ns;
         longint unsigned d, inner, t, rv;
         longint unsigned a, b, f;
         int unsigned w, idx;
         logic [7:0] nt;
         rbbu_pkg::rsp_type o;
         px = longint'(r.column_half) * 128;
         pz = longint'(r.row) * 256 + (r.column_half[0] ? 128 : 0);
         dx = px - longint'(c.center_x);
         dz = pz - longint'(c.center_z);
         d = isqrt(longint'(dx * dx) + longint'(dz * dz));
         inner = (longint'(c.hardness) * c.brush_radius) >> 8;
         if (d > inner && d < c.brush_radius) begin
            t = ((d - inner) << 16) / (longint'(c.brush_radius) - inner);
            t &= 16'hFFFF;
            a = rbbu_pkg::COS_TAB[t >> 12];
            b = rbbu_pkg::COS_TAB[(t >> 12) + 1];
            f = t & 4095;
            w = a - (((a - b) * f) >> 12);
         end else begin
            w = (d <= inner) ? 65536 : 0;
         end
         amt = longint'($signed(c.step_amount));
         prod = longint'(w) * amt;
         delta = (prod >= 0) ? (prod >>> 16) : -(((-prod) + 65535) >>> 16);
         if (c.tex_mode == rbbu_pkg::MODE_RANDOM) begin
            rv = rbbu_pkg::RND_TAB[{r.column_half[4:0], r.row[3:0]}];
            rv = (rv * c.tex_value) / 1000000;
            ns = longint'(r.size_in) + delta;
            nt = (rv > 255) ? 8'd255 : rv[7:0];
         end else if (c.tex_mode == rbbu_pkg::MODE_FIXED) begin
            idx = c.tex_value[7:0];
            if (idx != r.tex_in) begin
               if (w > 0) begin
                  ns = delta;
                  nt = idx[7:0];
               end else begin
                  ns = r.size_in;
                  nt = r.tex_in;
               end
            end else begin
               ns = longint'(r.size_in) + delta;
               nt = r.tex_in;
            end
         end else begin
            // erase, and the unused fourth mode too
            ns = 0;
            nt = 0;
         end
         if (ns < 0) ns = 0;
         if (ns > longint'(c.max_size)) ns = c.max_size;
         o.size_out = ns[15:0];
         o.tex_out = nt;
         return o;
      endfunction

      function void note_request(rbbu_pkg::req_type r, brush_cfg_type c);
         pending.push_back(predict_blade(r, c));
      endfunction

      function void check_response(rbbu_pkg::rsp_type got);
         rbbu_pkg::rsp_type exp_r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response size=%0d tex=%0d", got.size_out, got.tex_out);
            return;
         end
         exp_r = pending.pop_front();
         checked++;
         if (got.size_out !== exp_r.size_out || got.tex_out !== exp_r.tex_out) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected size=%0d tex=%0d, got size=%0d tex=%0d",
                        exp_r.size_out, exp_r.tex_out, got.size_out, got.tex_out);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rbbu_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rbbu_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rbbu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rbbu_pkg::CSR_DATA_W-1:0] csr_data = '0;

   radial_brush_blade_update_top dut (.*);

   always #4 clock = ~clock;

   blade_scoreboard sb = new();
   brush_cfg_type cfg;
   int unsigned cycle_count = 0;
   bit calm_phase = 1'b0;     // last part of the run: no idling at all
   bit hold_rsp = 1'b0;       // long receiver hold-off request
   int unsigned sent = 0;

   // transaction sampling on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data, cfg);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off, none in the calm phase
   initial begin : rsp_side
      int unsigned n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic write_reg(logic [rbbu_pkg::CSR_IDX_W-1:0] idx,
                            logic [rbbu_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         rbbu_pkg::REG_CENTER_X:     cfg.center_x = val[18:0];
         rbbu_pkg::REG_CENTER_Z:     cfg.center_z = val[16:0];
         rbbu_pkg::REG_BRUSH_RADIUS: cfg.brush_radius = val[15:0];
         rbbu_pkg::REG_HARDNESS:     cfg.hardness = val[8:0];
         rbbu_pkg::REG_STEP_AMOUNT:  cfg.step_amount = val[15:0];
         rbbu_pkg::REG_MAX_SIZE:     cfg.max_size = val[15:0];
         rbbu_pkg::REG_TEX_MODE:     cfg.tex_mode = val[1:0];
         rbbu_pkg::REG_TEX_VALUE:    cfg.tex_value = val[8:0];
         default: ;
      endcase
   endtask

   // one request transaction, with an optional idle burst ahead of it
   task automatic send_blade(rbbu_pkg::req_type r);
      int unsigned n;
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 16);
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // lower valid, then wait until every pending update has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // random settings; extremes come up often
   task automatic pick_settings(int unsigned mode);
      write_reg(rbbu_pkg::REG_CENTER_X, $urandom_range(0, 3) == 0 ? 19'd262143 :
                19'($urandom_range(0, 262143)));
      write_reg(rbbu_pkg::REG_CENTER_Z, $urandom_range(0, 3) == 0 ? 19'd0 :
                19'($urandom_range(0, 65536)));
      write_reg(rbbu_pkg::REG_BRUSH_RADIUS, $urandom_range(0, 4) == 0 ? 19'd65535 :
                19'($urandom_range(256, 40000)));
      write_reg(rbbu_pkg::REG_HARDNESS, $urandom_range(0, 4) == 0 ?
                19'($urandom_range(257, 511)) : 19'($urandom_range(0, 256)));
      write_reg(rbbu_pkg::REG_STEP_AMOUNT, 19'($urandom_range(0, 65535)));
      write_reg(rbbu_pkg::REG_MAX_SIZE, $urandom_range(0, 3) == 0 ?
                19'($urandom_range(0, 65535)) : 19'd65535);
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'(mode));
      write_reg(rbbu_pkg::REG_TEX_VALUE, 19'($urandom_range(0, 511)));
   endtask

   // element drawn near the brush center, so the falloff band is hit
   function automatic rbbu_pkg::req_type near_blade();
      rbbu_pkg::req_type r;
      int cx, cz, s;
      s = int'(cfg.brush_radius) + 512;
      cx = int'(cfg.center_x) / 128 + $urandom_range(0, 2 * (s / 128 + 1)) - (s / 128 + 1);
      cz = int'(cfg.center_z) / 256 + $urandom_range(0, 2 * (s / 256 + 1)) - (s / 256 + 1);
      r.column_half = (cx < 0) ? 11'd0 : (cx > 2047) ? 11'd2047 : cx[10:0];
      r.row = (cz < 0) ? 8'd0 : (cz > 255) ? 8'd255 : cz[7:0];
      r.size_in = 16'($urandom_range(0, 65535));
      r.tex_in = ($urandom_range(0, 2) == 0) ? cfg.tex_value[7:0] : 8'($urandom_range(0, 255));
      return r;
   endfunction

   initial begin : stimulus
      rbbu_pkg::req_type r;
      int unsigned phase, k, mode;
      cfg = '{center_x: 0, center_z: 0, brush_radius: 0, hardness: 256,
              step_amount: 0, max_size: 65535, tex_mode: rbbu_pkg::MODE_FIXED, tex_value: 0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a brush mid-grid with a falloff band, extremes of each field
      write_reg(rbbu_pkg::REG_CENTER_X, 19'd131072);
      write_reg(rbbu_pkg::REG_CENTER_Z, 19'd32768);
      write_reg(rbbu_pkg::REG_BRUSH_RADIUS, 19'd2048);
      write_reg(rbbu_pkg::REG_HARDNESS, 19'd128);
      write_reg(rbbu_pkg::REG_STEP_AMOUNT, 19'd32767);
      write_reg(rbbu_pkg::REG_MAX_SIZE, 19'd65535);
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'(rbbu_pkg::MODE_FIXED));
      write_reg(rbbu_pkg::REG_TEX_VALUE, 19'd300);   // index above 255: low byte used
      send_blade('{column_half: 11'd1024, row: 8'd128, size_in: 16'hFFFF, tex_in: 8'd44});
      send_blade('{column_half: 11'd1030, row: 8'd128, size_in: 16'd0, tex_in: 8'd7});
      send_blade('{column_half: 11'd1037, row: 8'd131, size_in: 16'd100, tex_in: 8'd44});
      send_blade('{column_half: 11'd2047, row: 8'd255, size_in: 16'd5, tex_in: 8'd255});
      send_blade('{column_half: 11'd0, row: 8'd0, size_in: 16'hFFFF, tex_in: 8'd0});
      drain();
      // shrink below zero, random mode with saturating texture
      write_reg(rbbu_pkg::REG_STEP_AMOUNT, 19'h08000);
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'(rbbu_pkg::MODE_RANDOM));
      write_reg(rbbu_pkg::REG_TEX_VALUE, 19'd511);
      send_blade('{column_half: 11'd1024, row: 8'd128, size_in: 16'd10, tex_in: 8'd1});
      send_blade('{column_half: 11'd1033, row: 8'd129, size_in: 16'd40000, tex_in: 8'd2});
      send_blade('{column_half: 11'd1039, row: 8'd127, size_in: 16'd0, tex_in: 8'd3});
      drain();
      // hardness above one, zero-width band (radius zero), erase and mode three
      write_reg(rbbu_pkg::REG_HARDNESS, 19'd511);
      write_reg(rbbu_pkg::REG_MAX_SIZE, 19'd1000);
      write_reg(rbbu_pkg::REG_STEP_AMOUNT, 19'd300);
      send_blade('{column_half: 11'd1040, row: 8'd128, size_in: 16'd2000, tex_in: 8'd9});
      drain();
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'(rbbu_pkg::MODE_ERASE));
      send_blade('{column_half: 11'd1024, row: 8'd128, size_in: 16'd2000, tex_in: 8'd9});
      drain();
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'd3);
      write_reg(rbbu_pkg::REG_BRUSH_RADIUS, 19'd0);
      write_reg(rbbu_pkg::REG_HARDNESS, 19'd0);
      send_blade('{column_half: 11'd1024, row: 8'd128, size_in: 16'd77, tex_in: 8'd9});
      drain();
      write_reg(rbbu_pkg::REG_TEX_MODE, 19'(rbbu_pkg::MODE_FIXED));
      send_blade('{column_half: 11'd1024, row: 8'd128, size_in: 16'd77, tex_in: 8'd9});
      drain();

      // random phases across all modes
      for (phase = 0; phase < 26; phase++) begin
         mode = (phase % 5 == 4) ? $urandom_range(2, 3) : (phase % 2);
         pick_settings(mode);
         if (phase == 24) calm_phase = 1'b1;
         if (phase == 5) hold_rsp = 1'b1;   // input must back up behind this
         for (k = 0; k < 50; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               r = rbbu_pkg::req_type'(REQ_W'({$urandom, $urandom}));
            end else begin
               r = near_blade();
            end
            send_blade(r);
         end
         drain();   // also the pause until every result is back
      end

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d blade updates over 26 random brush settings in all modes,", sent);
      $display("checked %0d responses, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
